>>> rtl/smt_pkg.sv
// Shared types and constants for the session member table with aging.
package smt_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int ID_W         = 32;
    localparam int TIME_W       = 32;
    localparam int CNT_OUT_W    = 7;
    localparam int LOCAL_PARTY  = 1;

    // One stored entry: {valid, ssrc, time}.
    localparam int ENTRY_W      = 1 + ID_W + TIME_W;
    localparam int ENTRY_VLD    = ENTRY_W - 1;

    localparam int S_TDATA_W    = ID_W + 2 * TIME_W;
    localparam int M_TDATA_W    = 24;

    typedef enum logic [1:0] {
        OP_NOTE   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_REAP   = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic start;
        logic issue;
        logic commit;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_addr;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/smt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module smt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/smt_ctrl.sv
// Controller state machine: clearing pass, table scan, commit and result hand-off.
module smt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  smt_pkg::stat_t stat,
    output smt_pkg::cmd_t  cmd
);

    import smt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.last_addr)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_OUT;
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.start  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.issue  = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_COMMIT);
    assign cmd.load   = (state_reg == ST_OUT) && stat.out_free;

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN))
        else $error("accepted word did not start a scan");

    a_scan_ends_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> cmd.commit)
        else $error("drain not followed by commit");

    a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> s_tready)
        else $error("result load did not return to idle");

endmodule

>>> rtl/smt_datapath.sv
// Datapath: entry memory, scan address counter, match logic, counters and result register.
module smt_datapath #(
    parameter int ENTRIES = smt_pkg::ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  smt_pkg::cmd_t                   cmd,
    output smt_pkg::stat_t                  stat,
    input  smt_pkg::op_t                    op,
    input  logic [smt_pkg::ID_W-1:0]        ssrc,
    input  logic [smt_pkg::TIME_W-1:0]      time_count,
    input  logic [smt_pkg::TIME_W-1:0]      threshold,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smt_pkg::M_TDATA_W-1:0]   m_tdata
);

    import smt_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 2);
    localparam int RCNT_W = $clog2(ENTRIES + 1);

    // Latched input word.
    op_t                 op_reg;
    logic [ID_W-1:0]     ssrc_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   thr_reg;

    logic [IDX_W-1:0]    addr_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_valid_reg;

    logic                found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                was_new_reg;
    logic                full_reg;
    logic [RCNT_W-1:0]   reaped_reg;
    logic [CNT_W-1:0]    members_reg;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ENTRY_W-1:0]  rd_data;

    logic                last_addr;
    logic                ent_valid;
    logic [ID_W-1:0]     ent_ssrc;
    logic [TIME_W-1:0]   ent_time;
    logic                hit;
    logic                rm_clear;
    logic                reap_clear;
    logic                scan_clear;
    logic                note_write;
    logic                note_new;

    logic [CNT_W+CNT_OUT_W-1:0]  members_ext;
    logic [RCNT_W+CNT_OUT_W-1:0] reaped_ext;

    smt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.issue),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign last_addr  = (addr_reg == IDX_W'(ENTRIES - 1));
    assign ent_valid  = rd_data[ENTRY_VLD];
    assign ent_ssrc   = rd_data[ENTRY_VLD-1 -: ID_W];
    assign ent_time   = rd_data[TIME_W-1:0];
    assign hit        = rd_valid_reg && ent_valid && (ent_ssrc == ssrc_reg);

    // Remove drops only the first match; reap drops every stale entry it passes.
    assign rm_clear   = hit && (op_reg == OP_REMOVE) && !found_reg;
    assign reap_clear = rd_valid_reg && ent_valid && (op_reg == OP_REAP)
                        && (ent_time < thr_reg);
    assign scan_clear = rm_clear || reap_clear;

    assign note_write = cmd.commit && (op_reg == OP_NOTE) && (found_reg || free_found_reg);
    assign note_new   = note_write && !found_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        if (cmd.clear)
        begin
            wr_en = 1'b1;
        end
        else if (scan_clear)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg;
            wr_data = {1'b0, ent_ssrc, ent_time};
        end
        else if (note_write)
        begin
            wr_en   = 1'b1;
            wr_addr = found_reg ? match_idx_reg : free_idx_reg;
            wr_data = {1'b1, ssrc_reg, time_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= op;
            ssrc_reg <= ssrc;
            time_reg <= time_count;
            thr_reg  <= threshold;
        end
        if (cmd.issue)
        begin
            rd_idx_reg <= addr_reg;
        end
        if (hit && !found_reg)
        begin
            match_idx_reg <= rd_idx_reg;
        end
        if (rd_valid_reg && !ent_valid && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.load)
        begin
            m_tdata_reg <= {
                {(M_TDATA_W - 3 - 2 * CNT_OUT_W){1'b0}},
                members_ext[CNT_OUT_W-1:0],
                reaped_ext[CNT_OUT_W-1:0],
                full_reg,
                found_reg && (op_reg != OP_NOTE),
                was_new_reg
            };
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            was_new_reg    <= 1'b0;
            full_reg       <= 1'b0;
            reaped_reg     <= '0;
            members_reg    <= CNT_W'(LOCAL_PARTY);
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue;
            if (cmd.clear || cmd.issue)
            begin
                addr_reg <= last_addr ? '0 : addr_reg + 1'b1;
            end

            if (cmd.start)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                was_new_reg    <= 1'b0;
                full_reg       <= 1'b0;
                reaped_reg     <= '0;
            end
            else
            begin
                if (hit && (op_reg != OP_REAP))
                begin
                    found_reg <= 1'b1;
                end
                if (rd_valid_reg && !ent_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                if (reap_clear)
                begin
                    reaped_reg <= reaped_reg + 1'b1;
                end
                if (cmd.commit && (op_reg == OP_NOTE) && !found_reg)
                begin
                    was_new_reg <= free_found_reg;
                    full_reg    <= !free_found_reg;
                end
            end

            if (scan_clear)
            begin
                members_reg <= members_reg - 1'b1;
            end
            else if (note_new)
            begin
                members_reg <= members_reg + 1'b1;
            end

            if (cmd.load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign members_ext = {{CNT_OUT_W{1'b0}}, members_reg};
    assign reaped_ext  = {{CNT_OUT_W{1'b0}}, reaped_reg};

    assign stat.last_addr = last_addr;
    assign stat.out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = m_tdata_reg;

    a_members_range: assert property (@(posedge clk) disable iff (!rst_n)
        (members_reg >= CNT_W'(LOCAL_PARTY))
        && (members_reg <= CNT_W'(ENTRIES + LOCAL_PARTY)))
        else $error("member count out of range");

    a_commit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !rd_valid_reg)
        else $error("commit overlaps a scan read");

    a_new_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[2]))
        else $error("result flags both new and full");

endmodule

>>> rtl/ssrc_member_table_with_aging.sv
// Session member table with aging: top level joining controller and datapath.
//
// Usage: one input word carries an operation in s_tuser (note, remove, reap,
// lookup) and ssrc, time_count and threshold in s_tdata. Each accepted word
// gives exactly one result word on the m_ side with was_new, found,
// table_full, reaped_count and member_count.
// Every operation scans all ENTRIES entries of the table memory, one entry per
// cycle through its registered read port, then drains the last read, does the
// commit write and loads the result register once it is free. The next word
// is accepted only after that result has been loaded.
// After reset all ENTRIES entries of the table memory are swept clear, one
// entry a cycle; s_tready stays low during that pass. The member count starts at one
// for the local party.
// A finished result waits in the output register while m_tready is low; the
// next word may be accepted and scanned meanwhile, and its result is loaded
// only once the register is free.
module ssrc_member_table_with_aging #(
    parameter int ENTRIES = smt_pkg::ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: ssrc [31:0], time_count [63:32], threshold [95:64]
    input  logic [smt_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: op [1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: was_new [0], found [1], table_full [2], reaped_count [9:3],
    // member_count [16:10], zero fill [23:17]
    output logic [smt_pkg::M_TDATA_W-1:0]   m_tdata
);

    import smt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    smt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    smt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op_t'(s_tuser)),
        .ssrc       (s_tdata[ID_W-1:0]),
        .time_count (s_tdata[ID_W+TIME_W-1:ID_W]),
        .threshold  (s_tdata[S_TDATA_W-1:ID_W+TIME_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

>>> tb/ssrc_member_table_with_aging_tb.sv
// Self-checking stream testbench for the session member table with aging.
`timescale 1ns / 1ps

module ssrc_member_table_with_aging_tb;

    import smt_pkg::*;

    localparam int TABLE_DEPTH = ENTRIES_DEF;
    localparam int RANDOM_WORDS = 530;
    localparam int POOL_SIZE = 72;

    typedef struct packed {
        logic       was_new;
        logic       found;
        logic       table_full;
        logic [6:0] reaped_count;
        logic [6:0] member_count;
    } member_status_t;

    typedef struct {
        op_t            op;
        logic [31:0]    id;
        logic [31:0]    tc;
        logic [31:0]    thr;
        bit             typed;
        member_status_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata: ssrc [31:0], time_count [63:32], threshold [95:64]
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // s_tuser: op [1:0]
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata: was_new [0], found [1], table_full [2], reaped_count [9:3],
    // member_count [16:10], zero fill [23:17]
    logic [M_TDATA_W-1:0]   m_tdata;

    // Shadow copy of the table, advanced once per accepted word.
    bit          shadow_valid [TABLE_DEPTH];
    logic [31:0] shadow_ssrc [TABLE_DEPTH];
    logic [31:0] shadow_seen [TABLE_DEPTH];
    int          shadow_members = LOCAL_PARTY;

    member_status_t awaited_status [$];
    stim_row_t      directed_rows [$];
    logic [31:0]    id_pool [POOL_SIZE];
    int             mismatches = 0;
    int             words_sent = 0;
    int             results_taken = 0;

    ssrc_member_table_with_aging #(
        .ENTRIES (TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic member_status_t make_status(logic wn, logic fd, logic fl,
                                                   int reaped, int members);
        member_status_t st;
        st.was_new      = wn;
        st.found        = fd;
        st.table_full   = fl;
        st.reaped_count = reaped[6:0];
        st.member_count = members[6:0];
        return st;
    endfunction

    function automatic member_status_t apply_to_table(op_t op, logic [31:0] id,
                                                      logic [31:0] now, logic [31:0] thr);
        member_status_t st;
        int hit;
        int free_slot;
        int reaped;
        st = '0;
        hit = -1;
        free_slot = -1;
        reaped = 0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (shadow_valid[i] && shadow_ssrc[i] == id)
                hit = i;
            if (!shadow_valid[i])
                free_slot = i;
        end
        case (op)
            OP_NOTE:
            begin
                if (hit >= 0)
                    shadow_seen[hit] = now;
                else if (free_slot >= 0)
                begin
                    shadow_valid[free_slot] = 1'b1;
                    shadow_ssrc[free_slot] = id;
                    shadow_seen[free_slot] = now;
                    shadow_members++;
                    st.was_new = 1'b1;
                end
                else
                    st.table_full = 1'b1;
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    shadow_valid[hit] = 1'b0;
                    shadow_members--;
                    st.found = 1'b1;
                end
            end
            OP_REAP:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (shadow_valid[i] && shadow_seen[i] < thr)
                    begin
                        shadow_valid[i] = 1'b0;
                        shadow_members--;
                        reaped++;
                    end
                end
            end
            default:
                st.found = (hit >= 0);
        endcase
        st.reaped_count = reaped[6:0];
        st.member_count = shadow_members[6:0];
        return st;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic add_row(op_t op, logic [31:0] id, logic [31:0] tc, logic [31:0] thr,
                           bit typed, member_status_t want);
        stim_row_t r;
        r.op = op;
        r.id = id;
        r.tc = tc;
        r.thr = thr;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    // A zero gap keeps tvalid high straight into the next word.
    task automatic offer_word(op_t op, logic [31:0] id, logic [31:0] tc, logic [31:0] thr,
                              bit typed, member_status_t want);
        int gap;
        member_status_t predicted;
        gap = ((words_sent / 40) % 3 == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {thr, tc, id};
        do @(posedge clk); while (!s_tready);
        predicted = apply_to_table(op, id, tc, thr);
        awaited_status.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // Result side: random stalls, one long hold-off to back the block up.
    initial
    begin
        int stall;
        member_status_t want;
        forever
        begin
            if (results_taken == 200)
                stall = 700;
            else if ((results_taken / 50) % 3 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_taken++;
            if (awaited_status.size() == 0)
                flag_mismatch("result word with nothing pending", m_tdata, 0);
            else
            begin
                want = awaited_status.pop_front();
                if (m_tdata[0] !== want.was_new)
                    flag_mismatch("was_new", m_tdata[0], want.was_new);
                if (m_tdata[1] !== want.found)
                    flag_mismatch("found", m_tdata[1], want.found);
                if (m_tdata[2] !== want.table_full)
                    flag_mismatch("table_full", m_tdata[2], want.table_full);
                if (m_tdata[9:3] !== want.reaped_count)
                    flag_mismatch("reaped_count", m_tdata[9:3], want.reaped_count);
                if (m_tdata[16:10] !== want.member_count)
                    flag_mismatch("member_count", m_tdata[16:10], want.member_count);
                if (m_tdata[23:17] !== '0)
                    flag_mismatch("zero fill", m_tdata[23:17], 0);
            end
        end
    end

    initial
    begin
        logic [31:0] now_count;
        logic [31:0] id;
        logic [31:0] tc;
        logic [31:0] thr;
        op_t op;
        int pick;
        int fill_ptr;
        bit filling;

        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_row(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1, make_status(0, 0, 0, 0, 1));
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, make_status(0, 0, 0, 0, 1));
        add_row(OP_REAP, 32'h0, 32'h0, 32'hFFFF_FFFF, 1, make_status(0, 0, 0, 0, 1));
        add_row(OP_NOTE, 32'h0, 32'h0, 32'h0, 1, make_status(1, 0, 0, 0, 2));
        add_row(OP_NOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                make_status(1, 0, 0, 0, 3));
        // Same identifier again only refreshes its time.
        add_row(OP_NOTE, 32'h0, 32'd5, 32'h0, 1, make_status(0, 0, 0, 0, 3));
        add_row(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1, make_status(0, 1, 0, 0, 3));
        add_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, make_status(0, 1, 0, 0, 3));
        add_row(OP_LOOKUP, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                make_status(0, 0, 0, 0, 3));
        add_row(OP_REAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, make_status(0, 0, 0, 0, 3));
        add_row(OP_REAP, 32'h0, 32'h0, 32'd5, 0, '0);
        add_row(OP_REAP, 32'h0, 32'h0, 32'd6, 1, make_status(0, 0, 0, 1, 2));
        add_row(OP_REAP, 32'h0, 32'h0, 32'hFFFF_FFFF, 0, '0);
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, make_status(0, 1, 0, 0, 1));
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, make_status(0, 0, 0, 0, 1));
        add_row(OP_NOTE, 32'h1234_5678, 32'd100, 32'h0, 0, '0);
        add_row(OP_NOTE, 32'hA5A5_A5A5, 32'd200, 32'h0, 0, '0);
        add_row(OP_REMOVE, 32'h1234_5678, 32'h0, 32'h0, 0, '0);
        add_row(OP_NOTE, 32'h5A5A_5A5A, 32'd300, 32'h0, 0, '0);
        add_row(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 0, '0);
        add_row(OP_REAP, 32'h0, 32'h0, 32'hFFFF_FFFF, 0, '0);

        foreach (directed_rows[i])
            offer_word(directed_rows[i].op, directed_rows[i].id, directed_rows[i].tc,
                       directed_rows[i].thr, directed_rows[i].typed, directed_rows[i].want);

        foreach (id_pool[i])
            id_pool[i] = $urandom;
        now_count = 32'd1000;
        fill_ptr = 0;

        // Fill phases mostly note pool identifiers in turn until the table overflows;
        // mixed phases open with a reap of everything and then churn at random.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            filling = ((i / 90) % 2 == 0);
            now_count = now_count + $urandom_range(0, 4);
            id = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, POOL_SIZE - 1)];
            tc = ($urandom_range(0, 19) == 0) ? $urandom : now_count;
            thr = $urandom;
            pick = $urandom_range(0, 99);
            if (filling)
            begin
                if (pick < 90)
                begin
                    op = OP_NOTE;
                    id = id_pool[fill_ptr % POOL_SIZE];
                    fill_ptr++;
                end
                else if (pick < 96)
                    op = OP_LOOKUP;
                else
                    op = OP_REMOVE;
            end
            else if (i % 90 == 0)
            begin
                op = OP_REAP;
                thr = 32'hFFFF_FFFF;
            end
            else if (pick < 35)
                op = OP_NOTE;
            else if (pick < 60)
                op = OP_LOOKUP;
            else if (pick < 80)
                op = OP_REMOVE;
            else
            begin
                op = OP_REAP;
                case ($urandom_range(0, 9))
                    0: thr = 32'h0;
                    1: thr = 32'hFFFF_FFFF;
                    2: thr = $urandom;
                    default: thr = now_count - $urandom_range(0, 60);
                endcase
            end
            if (op != OP_NOTE)
                tc = $urandom;
            offer_word(op, id, tc, thr, 0, '0);
        end
        s_tvalid <= 1'b0;

        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/smt_pkg.sv
rtl/smt_ram.sv
rtl/smt_ctrl.sv
rtl/smt_datapath.sv
rtl/ssrc_member_table_with_aging.sv
tb/ssrc_member_table_with_aging_tb.sv
